// ===== rtl/core/slcfp_pkg.sv =====
// shared types and constants of the sync/length/checksum frame parser
package slcfp_pkg;

  localparam logic [7:0] Sync1Byte = 8'h5A;
  localparam logic [7:0] Sync2Byte = 8'hA5;
  localparam logic [15:0] SumBase = 16'hFFFF;

  localparam int unsigned PosW = 9;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    OpLen,
    OpSrc,
    OpDst,
    OpCmd,
    OpArg,
    OpPay,
    OpSumLo,
    OpSumHi,
    OpTooLong
  } op_e;

  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindOk      = 2'd1,
    KindBadSum  = 2'd2,
    KindTooLong = 2'd3
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
  } token_t;

endpackage

// ===== rtl/core/slcfp_front.sv =====
// front end: tracks frame phase and position, classifies each byte after the sync pair into a token
module slcfp_front import slcfp_pkg::*; #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output token_t     token_o
);

  typedef enum logic [3:0] {
    PhSync1,
    PhSync2,
    PhLen,
    PhSrc,
    PhDst,
    PhCmd,
    PhArg,
    PhPay,
    PhSumLo,
    PhSumHi
  } phase_e;

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME);

  phase_e          phase_q, phase_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] pos_inc;
  logic [8:0]      cnt_next;
  logic            advance;
  logic            tok_valid;
  op_e             tok_op;

  assign pos_inc  = pos_q + 1'b1;
  assign cnt_next = {1'b0, cnt_q} + 9'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    advance   = 1'b1;
    tok_valid = 1'b0;
    tok_op    = OpLen;
    if (accept_i) begin
      unique case (phase_q)
        PhSync1: begin
          if (rx_byte_i == Sync1Byte) begin
            phase_d = PhSync2;
          end else begin
            advance = 1'b0;
          end
        end
        PhSync2: begin
          if (rx_byte_i == Sync2Byte) begin
            phase_d = PhLen;
          end else begin
            advance = 1'b0;
            phase_d = PhSync1;
            pos_d   = '0;
          end
        end
        PhLen: begin
          len_d     = rx_byte_i;
          tok_valid = 1'b1;
          tok_op    = OpLen;
          phase_d   = PhSrc;
        end
        PhSrc: begin
          tok_valid = 1'b1;
          tok_op    = OpSrc;
          phase_d   = PhDst;
        end
        PhDst: begin
          tok_valid = 1'b1;
          tok_op    = OpDst;
          phase_d   = PhCmd;
        end
        PhCmd: begin
          tok_valid = 1'b1;
          tok_op    = OpCmd;
          phase_d   = PhArg;
        end
        PhArg: begin
          tok_valid = 1'b1;
          tok_op    = OpArg;
          cnt_d     = '0;
          phase_d   = (len_q == 8'd0) ? PhSumLo : PhPay;
        end
        PhPay: begin
          tok_valid = 1'b1;
          tok_op    = OpPay;
          cnt_d     = cnt_next[7:0];
          if (cnt_next >= {1'b0, len_q}) begin
            phase_d = PhSumLo;
          end
        end
        PhSumLo: begin
          tok_valid = 1'b1;
          tok_op    = OpSumLo;
          phase_d   = PhSumHi;
        end
        PhSumHi: begin
          advance   = 1'b0;
          tok_valid = 1'b1;
          tok_op    = OpSumHi;
          phase_d   = PhSync1;
          pos_d     = '0;
        end
        default: begin
          advance = 1'b0;
          phase_d = PhSync1;
          pos_d   = '0;
        end
      endcase
      if (advance) begin
        pos_d = pos_inc;
        if (pos_inc >= MaxPos) begin
          tok_valid = 1'b1;
          tok_op    = OpTooLong;
          phase_d   = PhSync1;
          pos_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync1;
      len_q   <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  assign push_o        = tok_valid;
  assign token_o.op    = tok_op;
  assign token_o.value = rx_byte_i;

endmodule

// ===== rtl/core/slcfp_queue.sv =====
// short token queue between front end and back end
module slcfp_queue import slcfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_token_i,
  input  logic   pop_i,
  output token_t pop_token_o,
  output logic   empty_o,
  output logic   full_o
);

  token_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign empty_o     = (count_q == '0);
  assign full_o      = (count_q == QCntW'(QDepth));
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_token_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/slcfp_back.sv =====
// back end: header capture, running sum, checksum check and result register
module slcfp_back import slcfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  token_t     token_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic [7:0] index_o,
  output logic [7:0] length_o,
  output logic [7:0] source_o,
  output logic [7:0] destination_o,
  output logic [7:0] command_o,
  output logic [7:0] argument_o
);

  logic [7:0]  len_q, src_q, dst_q, cmd_q, arg_q, idx_q, lo_q;
  logic [15:0] sum_q;
  logic        out_valid_q;
  kind_e       kind_q;
  logic [7:0]  data_q, index_q;
  logic        pop;
  logic        emit;
  logic [15:0] got;
  logic [15:0] want;

  assign pop  = !empty_i && (!out_valid_q || !out_stall_i);
  assign emit = pop && ((token_i.op == OpPay) || (token_i.op == OpSumHi) ||
                        (token_i.op == OpTooLong));
  assign got  = {token_i.value, lo_q};
  assign want = SumBase - sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      cmd_q       <= '0;
      arg_q       <= '0;
      idx_q       <= '0;
      lo_q        <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      if (pop) begin
        unique case (token_i.op)
          OpLen: begin
            len_q <= token_i.value;
            sum_q <= {8'd0, token_i.value};
          end
          OpSrc: begin
            src_q <= token_i.value;
            sum_q <= sum_q + {8'd0, token_i.value};
          end
          OpDst: begin
            dst_q <= token_i.value;
            sum_q <= sum_q + {8'd0, token_i.value};
          end
          OpCmd: begin
            cmd_q <= token_i.value;
            sum_q <= sum_q + {8'd0, token_i.value};
          end
          OpArg: begin
            arg_q <= token_i.value;
            sum_q <= sum_q + {8'd0, token_i.value};
            idx_q <= '0;
          end
          OpPay: begin
            sum_q <= sum_q + {8'd0, token_i.value};
            idx_q <= idx_q + 1'b1;
          end
          OpSumLo: lo_q <= token_i.value;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      unique case (token_i.op)
        OpPay: begin
          kind_q  <= KindData;
          data_q  <= token_i.value;
          index_q <= idx_q;
        end
        OpSumHi: begin
          kind_q  <= (got == want) ? KindOk : KindBadSum;
          data_q  <= '0;
          index_q <= '0;
        end
        default: begin
          kind_q  <= KindTooLong;
          data_q  <= '0;
          index_q <= '0;
        end
      endcase
    end
  end

  assign pop_o         = pop;
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign data_o        = data_q;
  assign index_o       = index_q;
  assign length_o      = len_q;
  assign source_o      = src_q;
  assign destination_o = dst_q;
  assign command_o     = cmd_q;
  assign argument_o    = arg_q;

endmodule

// ===== rtl/core/sync_length_checksum_frame_parser.sv =====
// top level of the sync/length/checksum frame parser
//
//   channel  valid        stall        payload
//   input    in_valid_i   in_stall_o   rx_byte_i
//   output   out_valid_o  out_stall_i  kind_o data_o index_o length_o source_o
//                                      destination_o command_o argument_o
//
// one byte per cycle while the token queue is not full; the front end classifies a byte
// in its accept cycle, and results reach the output register by way of the token queue
// a four-entry token queue separates front end and back end
// input stalls only while the token queue is full
// reset hunts for the first sync byte with all header fields zero
module sync_length_checksum_frame_parser import slcfp_pkg::*; #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic [7:0] index_o,
  output logic [7:0] length_o,
  output logic [7:0] source_o,
  output logic [7:0] destination_o,
  output logic [7:0] command_o,
  output logic [7:0] argument_o
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  token_t push_token;
  token_t pop_token;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  slcfp_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .token_o  (push_token)
  );

  slcfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_token_i(push_token),
    .pop_i       (pop),
    .pop_token_o (pop_token),
    .empty_o     (empty),
    .full_o      (full)
  );

  slcfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .token_i      (pop_token),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .index_o      (index_o),
    .length_o     (length_o),
    .source_o     (source_o),
    .destination_o(destination_o),
    .command_o    (command_o),
    .argument_o   (argument_o)
  );

endmodule
